// ===== rtl/thread_queue_scheduler_core_defines.svh =====
// Assertion macros shared by the thread queue scheduler RTL.
// Expects clk and rst_n in scope where used; no other dependencies.
`ifndef THREAD_QUEUE_SCHEDULER_CORE_DEFINES_SVH
`define THREAD_QUEUE_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication
`define TQS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tqs_pkg.sv =====
// Package for the thread queue scheduler: sizes, codes, beat and memory types.
// No dependencies.
package tqs_pkg;

  localparam int NUM_THREADS = 64;
  localparam int NUM_QUEUES  = NUM_THREADS + 1;
  localparam int SLOT_W      = $clog2(NUM_THREADS);
  localparam int LINK_W      = $clog2(NUM_THREADS + 1);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LINK_W-1:0] link_t;

  localparam link_t NIL     = LINK_W'(NUM_THREADS);
  localparam link_t READY_Q = LINK_W'(NUM_THREADS);

  typedef enum logic [2:0] {
    REQ_ENQUEUE = 3'd0,
    REQ_DEQUEUE = 3'd1,
    REQ_REMOVE  = 3'd2,
    REQ_SPAWN   = 3'd3,
    REQ_YIELD   = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_RUN   = 2'd1,
    ST_SLEEP = 2'd2,
    ST_DEAD  = 2'd3
  } slot_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_LAST,
    S_PUSH_SELF,
    S_POP_RD,
    S_POP_HEAD,
    S_POP_FIRST,
    S_POP_AFTER,
    S_RM_RD,
    S_RM_SELF,
    S_RM_BEFORE,
    S_RM_AFTER,
    S_STAT_RD,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [2:0] req_type;
    link_t      queue_index;
    slot_t      thread_id;
  } in_beat_t;

  typedef struct packed {
    link_t       result_thread;
    slot_t       current_thread;
    slot_state_t slot_state;
  } out_beat_t;

  typedef struct packed {
    slot_state_t status;
    link_t       prev;
    link_t       next;
  } slot_ent_t;

  typedef struct packed {
    logic      en;
    slot_t     addr;
    logic      we_status;
    logic      we_prev;
    logic      we_next;
    slot_ent_t data;
  } slot_wr_t;

  typedef struct packed {
    link_t head;
    link_t tail;
  } queue_ent_t;

  typedef struct packed {
    logic       en;
    link_t      addr;
    logic       we_head;
    logic       we_tail;
    queue_ent_t data;
  } queue_wr_t;

endpackage

// ===== rtl/tqs_slot_mem.sv =====
// Per-slot memory: state plus prev/next links, field write enables, registered read.
// Valid bits give reset values to entries never written. Uses tqs_pkg.
module tqs_slot_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  tqs_pkg::slot_t    rd_addr,
  output tqs_pkg::slot_ent_t rd_data,
  input  tqs_pkg::slot_wr_t wr
);

  tqs_pkg::slot_ent_t mem [tqs_pkg::NUM_THREADS];

  logic [tqs_pkg::NUM_THREADS-1:0] vld_r;
  tqs_pkg::slot_ent_t              rd_q_r;
  logic                            rd_vld_r;
  tqs_pkg::slot_t                  rd_addr_r;
  tqs_pkg::slot_state_t            wr_dflt_status;
  logic                            wr_fresh;

  assign wr_dflt_status = (wr.addr == '0) ? tqs_pkg::ST_RUN : tqs_pkg::ST_DEAD;
  assign wr_fresh       = !vld_r[wr.addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.we_status || wr_fresh) begin
        mem[wr.addr].status <= wr.we_status ? wr.data.status : wr_dflt_status;
      end
      if (wr.we_prev || wr_fresh) begin
        mem[wr.addr].prev <= wr.we_prev ? wr.data.prev : tqs_pkg::NIL;
      end
      if (wr.we_next || wr_fresh) begin
        mem[wr.addr].next <= wr.we_next ? wr.data.next : tqs_pkg::NIL;
      end
    end
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_comb begin
    if (rd_vld_r) begin
      rd_data = rd_q_r;
    end else begin
      rd_data.status = (rd_addr_r == '0) ? tqs_pkg::ST_RUN : tqs_pkg::ST_DEAD;
      rd_data.prev   = tqs_pkg::NIL;
      rd_data.next   = tqs_pkg::NIL;
    end
  end

endmodule

// ===== rtl/tqs_queue_mem.sv =====
// Queue memory: head/tail per queue (thread queues plus ready queue), registered read.
// Valid bits make unwritten queues read empty. Uses tqs_pkg.
module tqs_queue_mem (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  tqs_pkg::link_t      rd_addr,
  output tqs_pkg::queue_ent_t rd_data,
  input  tqs_pkg::queue_wr_t  wr
);

  tqs_pkg::queue_ent_t mem [tqs_pkg::NUM_QUEUES];

  logic [tqs_pkg::NUM_QUEUES-1:0] vld_r;
  tqs_pkg::queue_ent_t            rd_q_r;
  logic                           rd_vld_r;
  logic                           wr_fresh;

  assign wr_fresh = !vld_r[wr.addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.we_head || wr_fresh) begin
        mem[wr.addr].head <= wr.we_head ? wr.data.head : tqs_pkg::NIL;
      end
      if (wr.we_tail || wr_fresh) begin
        mem[wr.addr].tail <= wr.we_tail ? wr.data.tail : tqs_pkg::NIL;
      end
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_comb begin
    if (rd_vld_r) begin
      rd_data = rd_q_r;
    end else begin
      rd_data.head = tqs_pkg::NIL;
      rd_data.tail = tqs_pkg::NIL;
    end
  end

endmodule

// ===== rtl/tqs_seq.sv =====
// Request sequencer: read-modify-write steps over the slot and queue memories,
// running-slot register and result register. Uses tqs_pkg and the defines header.
`include "thread_queue_scheduler_core_defines.svh"

module tqs_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tqs_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output tqs_pkg::out_beat_t  out_beat,
  output logic                slot_rd_en,
  output tqs_pkg::slot_t      slot_rd_addr,
  input  tqs_pkg::slot_ent_t  slot_rd_data,
  output tqs_pkg::slot_wr_t   slot_wr,
  output logic                q_rd_en,
  output tqs_pkg::link_t      q_rd_addr,
  input  tqs_pkg::queue_ent_t q_rd_data,
  output tqs_pkg::queue_wr_t  q_wr
);

  localparam int SW = tqs_pkg::SLOT_W;

  tqs_pkg::seq_state_t state_r, state_nxt;
  logic [2:0]          req_r;
  tqs_pkg::link_t      qsel_r;
  tqs_pkg::slot_t      t_r;
  tqs_pkg::slot_t      slot_r;
  tqs_pkg::link_t      last_r;
  tqs_pkg::link_t      after_r;
  tqs_pkg::link_t      popped_r;
  tqs_pkg::slot_t      run_r;
  logic                out_vld_r;
  tqs_pkg::out_beat_t  out_r;

  logic accept;
  logic load;
  logic q_ok;
  logic is_yield;

  assign in_stall  = (state_r != tqs_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign load      = (state_r == tqs_pkg::S_DONE) && (!out_vld_r || !out_stall);
  assign q_ok      = (in_beat.queue_index <= tqs_pkg::READY_Q);
  assign is_yield  = (req_r == tqs_pkg::REQ_YIELD);
  assign out_valid = out_vld_r;
  assign out_beat  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tqs_pkg::S_IDLE: begin
        if (accept) begin
          case (in_beat.req_type)
            tqs_pkg::REQ_ENQUEUE: state_nxt = q_ok ? tqs_pkg::S_PUSH_RD : tqs_pkg::S_STAT_RD;
            tqs_pkg::REQ_DEQUEUE: state_nxt = q_ok ? tqs_pkg::S_POP_RD : tqs_pkg::S_STAT_RD;
            tqs_pkg::REQ_REMOVE:  state_nxt = q_ok ? tqs_pkg::S_RM_RD : tqs_pkg::S_STAT_RD;
            tqs_pkg::REQ_SPAWN:   state_nxt = tqs_pkg::S_PUSH_RD;
            tqs_pkg::REQ_YIELD:   state_nxt = tqs_pkg::S_PUSH_RD;
            default:              state_nxt = tqs_pkg::S_STAT_RD;
          endcase
        end
      end
      tqs_pkg::S_PUSH_RD:   state_nxt = tqs_pkg::S_PUSH_LAST;
      tqs_pkg::S_PUSH_LAST: state_nxt = tqs_pkg::S_PUSH_SELF;
      tqs_pkg::S_PUSH_SELF: state_nxt = is_yield ? tqs_pkg::S_POP_RD : tqs_pkg::S_STAT_RD;
      tqs_pkg::S_POP_RD:    state_nxt = tqs_pkg::S_POP_HEAD;
      tqs_pkg::S_POP_HEAD: begin
        state_nxt = (q_rd_data.head == tqs_pkg::NIL) ? tqs_pkg::S_STAT_RD
                                                     : tqs_pkg::S_POP_FIRST;
      end
      tqs_pkg::S_POP_FIRST: begin
        state_nxt = (slot_rd_data.next == tqs_pkg::NIL) ? tqs_pkg::S_STAT_RD
                                                        : tqs_pkg::S_POP_AFTER;
      end
      tqs_pkg::S_POP_AFTER: state_nxt = tqs_pkg::S_STAT_RD;
      tqs_pkg::S_RM_RD:     state_nxt = tqs_pkg::S_RM_SELF;
      tqs_pkg::S_RM_SELF:   state_nxt = tqs_pkg::S_RM_BEFORE;
      tqs_pkg::S_RM_BEFORE: state_nxt = tqs_pkg::S_RM_AFTER;
      tqs_pkg::S_RM_AFTER:  state_nxt = tqs_pkg::S_STAT_RD;
      tqs_pkg::S_STAT_RD:   state_nxt = tqs_pkg::S_DONE;
      tqs_pkg::S_DONE:      state_nxt = load ? tqs_pkg::S_IDLE : tqs_pkg::S_DONE;
      default:              state_nxt = tqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    slot_rd_en   = 1'b0;
    slot_rd_addr = t_r;
    slot_wr      = '0;
    q_rd_en      = 1'b0;
    q_rd_addr    = qsel_r;
    q_wr         = '0;
    q_wr.addr    = qsel_r;
    case (state_r)
      tqs_pkg::S_PUSH_RD: begin
        q_rd_en = 1'b1;
      end
      tqs_pkg::S_PUSH_LAST: begin
        q_wr.en        = 1'b1;
        q_wr.we_tail   = 1'b1;
        q_wr.data.tail = tqs_pkg::link_t'(slot_r);
        q_wr.we_head   = (q_rd_data.tail == tqs_pkg::NIL);
        q_wr.data.head = tqs_pkg::link_t'(slot_r);
        if (q_rd_data.tail != tqs_pkg::NIL) begin
          slot_wr.en        = 1'b1;
          slot_wr.addr      = q_rd_data.tail[SW-1:0];
          slot_wr.we_next   = 1'b1;
          slot_wr.data.next = tqs_pkg::link_t'(slot_r);
        end
      end
      tqs_pkg::S_PUSH_SELF: begin
        slot_wr.en          = 1'b1;
        slot_wr.addr        = slot_r;
        slot_wr.we_prev     = 1'b1;
        slot_wr.we_next     = 1'b1;
        slot_wr.we_status   = (req_r != tqs_pkg::REQ_ENQUEUE);
        slot_wr.data.prev   = last_r;
        slot_wr.data.next   = tqs_pkg::NIL;
        slot_wr.data.status = tqs_pkg::ST_READY;
      end
      tqs_pkg::S_POP_RD: begin
        q_rd_en = 1'b1;
      end
      tqs_pkg::S_POP_HEAD: begin
        if (q_rd_data.head != tqs_pkg::NIL) begin
          slot_rd_en   = 1'b1;
          slot_rd_addr = q_rd_data.head[SW-1:0];
        end
      end
      tqs_pkg::S_POP_FIRST: begin
        slot_wr.en          = 1'b1;
        slot_wr.addr        = last_r[SW-1:0];
        slot_wr.we_next     = 1'b1;
        slot_wr.data.next   = tqs_pkg::NIL;
        slot_wr.we_status   = is_yield;
        slot_wr.data.status = tqs_pkg::ST_RUN;
        q_wr.en             = 1'b1;
        q_wr.we_head        = 1'b1;
        q_wr.data.head      = slot_rd_data.next;
        q_wr.we_tail        = (slot_rd_data.next == tqs_pkg::NIL);
        q_wr.data.tail      = tqs_pkg::NIL;
      end
      tqs_pkg::S_POP_AFTER: begin
        slot_wr.en        = 1'b1;
        slot_wr.addr      = after_r[SW-1:0];
        slot_wr.we_prev   = 1'b1;
        slot_wr.data.prev = tqs_pkg::NIL;
      end
      tqs_pkg::S_RM_RD: begin
        slot_rd_en = 1'b1;
      end
      tqs_pkg::S_RM_SELF: begin
        slot_wr.en        = 1'b1;
        slot_wr.addr      = t_r;
        slot_wr.we_prev   = 1'b1;
        slot_wr.we_next   = 1'b1;
        slot_wr.data.prev = tqs_pkg::NIL;
        slot_wr.data.next = tqs_pkg::NIL;
        q_wr.en           = 1'b1;
        q_wr.we_head      = (slot_rd_data.prev == tqs_pkg::NIL);
        q_wr.data.head    = slot_rd_data.next;
        q_wr.we_tail      = (slot_rd_data.next == tqs_pkg::NIL);
        q_wr.data.tail    = slot_rd_data.prev;
      end
      tqs_pkg::S_RM_BEFORE: begin
        if (last_r != tqs_pkg::NIL) begin
          slot_wr.en        = 1'b1;
          slot_wr.addr      = last_r[SW-1:0];
          slot_wr.we_next   = 1'b1;
          slot_wr.data.next = after_r;
        end
      end
      tqs_pkg::S_RM_AFTER: begin
        if (after_r != tqs_pkg::NIL) begin
          slot_wr.en        = 1'b1;
          slot_wr.addr      = after_r[SW-1:0];
          slot_wr.we_prev   = 1'b1;
          slot_wr.data.prev = last_r;
        end
      end
      tqs_pkg::S_STAT_RD: begin
        slot_rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tqs_pkg::S_IDLE;
      out_vld_r <= 1'b0;
      run_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (state_r == tqs_pkg::S_POP_FIRST && is_yield) begin
        run_r <= last_r[SW-1:0];
      end
    end
  end

  // last_r carries the old tail (push), the popped head (pop) or prev (remove)
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_beat.req_type;
      t_r      <= in_beat.thread_id;
      popped_r <= tqs_pkg::NIL;
      if (in_beat.req_type == tqs_pkg::REQ_SPAWN || in_beat.req_type == tqs_pkg::REQ_YIELD) begin
        qsel_r <= tqs_pkg::READY_Q;
      end else begin
        qsel_r <= in_beat.queue_index;
      end
      slot_r <= (in_beat.req_type == tqs_pkg::REQ_YIELD) ? run_r : in_beat.thread_id;
    end
    case (state_r)
      tqs_pkg::S_PUSH_LAST: last_r <= q_rd_data.tail;
      tqs_pkg::S_POP_HEAD: begin
        last_r   <= q_rd_data.head;
        popped_r <= q_rd_data.head;
      end
      tqs_pkg::S_POP_FIRST: after_r <= slot_rd_data.next;
      tqs_pkg::S_RM_SELF: begin
        last_r  <= slot_rd_data.prev;
        after_r <= slot_rd_data.next;
      end
      default: begin
      end
    endcase
    if (load) begin
      out_r.result_thread  <= popped_r;
      out_r.current_thread <= run_r;
      out_r.slot_state     <= slot_rd_data.status;
    end
  end

  `TQS_ASSERT_SAME(a_slot_port_excl, slot_wr.en, !slot_rd_en, "slot memory read during write")
  `TQS_ASSERT_SAME(a_queue_port_excl, q_wr.en, !q_rd_en, "queue memory read during write")
  `TQS_ASSERT_NEXT(a_yield_runs_popped, state_r == tqs_pkg::S_POP_FIRST && is_yield, run_r == $past(last_r[SW-1:0]), "yield did not switch to popped slot")
  `TQS_ASSERT_NEXT(a_empty_pop, state_r == tqs_pkg::S_POP_HEAD && q_rd_data.head == tqs_pkg::NIL, popped_r == tqs_pkg::NIL && state_r == tqs_pkg::S_STAT_RD, "empty pop touched links")

endmodule

// ===== rtl/thread_queue_scheduler_core.sv =====
// Thread queue scheduler top level: sequencer plus slot and queue memories.
// Depends on tqs_pkg, tqs_seq, tqs_slot_mem, tqs_queue_mem.
//
//   beat      direction  handshake            payload
//   in_*      input      in_valid/in_stall    tqs_pkg::in_beat_t
//   out_*     output     out_valid/out_stall  tqs_pkg::out_beat_t
//
// One request at a time; in_stall stays high from accept until its result is registered.
// Unknown requests and out-of-range queues go straight to the status read; enqueue and
// spawn push onto a tail, dequeue pops a head, remove unlinks, and yield pushes then pops,
// each as a chain of dependent reads and writes of the slot and queue memories.
// Reset is synchronous; valid bits make both memories read as reset values at once.
// A pending result waits in the output register while the next request is accepted.
module thread_queue_scheduler_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tqs_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output tqs_pkg::out_beat_t out_beat
);

  logic                slot_rd_en;
  tqs_pkg::slot_t      slot_rd_addr;
  tqs_pkg::slot_ent_t  slot_rd_data;
  tqs_pkg::slot_wr_t   slot_wr;
  logic                q_rd_en;
  tqs_pkg::link_t      q_rd_addr;
  tqs_pkg::queue_ent_t q_rd_data;
  tqs_pkg::queue_wr_t  q_wr;

  tqs_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_beat      (in_beat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_beat     (out_beat),
    .slot_rd_en   (slot_rd_en),
    .slot_rd_addr (slot_rd_addr),
    .slot_rd_data (slot_rd_data),
    .slot_wr      (slot_wr),
    .q_rd_en      (q_rd_en),
    .q_rd_addr    (q_rd_addr),
    .q_rd_data    (q_rd_data),
    .q_wr         (q_wr)
  );

  tqs_slot_mem u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data),
    .wr      (slot_wr)
  );

  tqs_queue_mem u_queue_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (q_rd_en),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data),
    .wr      (q_wr)
  );

endmodule
